// ===== hdl/ots_pkg.sv =====
`timescale 1ns / 1ps
package ots_pkg;

  localparam int SMP_W    = 16;
  localparam int FRAC     = SMP_W - 1;
  localparam int WIDE_W   = SMP_W + 4;
  // drive and alpha are Q1.15 whatever the sample width
  localparam int COEF_FRAC = 15;
  // oversampling factor, power of two
  localparam int OS_N     = 4;
  localparam int OS_SHIFT = $clog2(OS_N);
  localparam int K_W      = (OS_SHIFT > 0) ? OS_SHIFT : 1;
  localparam int KD_W     = SMP_W + 1 + OS_SHIFT;
  localparam int SUM_W    = SMP_W + OS_SHIFT;
  localparam int OP_W     = SMP_W + 6;
  localparam int PROD_W   = 2 * OP_W;
  localparam int DIV_W    = 2 * SMP_W + 5;
  localparam int QB       = SMP_W;
  localparam int CNT_W    = $clog2(QB);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [SMP_W:0]    diff_t;
  typedef logic signed [KD_W-1:0]   kd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [DIV_W-1:0]         div_t;
  typedef logic [QB-1:0]            quo_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [K_W-1:0]           kidx_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;

  localparam cfg_idx_t REG_DRIVE  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ALPHA  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_MAKEUP = cfg_idx_t'(2);

  localparam cfg_word_t DRIVE_RST  = cfg_word_t'(32768);
  localparam cfg_word_t ALPHA_RST  = cfg_word_t'(19560);
  localparam cfg_word_t MAKEUP_RST = cfg_word_t'(4096);

  localparam op_t ONE_Q     = op_t'(1) <<< FRAC;
  localparam op_t TWO_ONE   = ONE_Q <<< 1;
  localparam op_t THREE_ONE = op_t'(ONE_Q * 3);
  localparam op_t K27_ONE   = op_t'(ONE_Q * 27);

  localparam kidx_t K_LAST = kidx_t'(OS_N - 1);
  localparam cnt_t  CNT_START = cnt_t'(QB - 1);
  localparam quo_t  SAT_Q = {1'b0, {(QB-1){1'b1}}};

  localparam logic signed [31:0] WIDE_MAX = (32'sd1 <<< (WIDE_W - 1)) - 32'sd1;
  localparam logic signed [31:0] WIDE_MIN = -(32'sd1 <<< (WIDE_W - 1));
  localparam logic signed [31:0] SMP_MAX  = (32'sd1 <<< (SMP_W - 1)) - 32'sd1;
  localparam logic signed [31:0] SMP_MIN  = -(32'sd1 <<< (SMP_W - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_PT,
    S_SQ,
    S_T,
    S_U,
    S_D,
    S_A,
    S_N,
    S_DIV,
    S_ACC,
    S_BL,
    S_S,
    S_F,
    S_O,
    S_WAIT
  } state_t;

  function automatic wide_t sat_wide(input logic signed [31:0] v);
    if (v > WIDE_MAX) begin
      return wide_t'(WIDE_MAX);
    end else if (v < WIDE_MIN) begin
      return wide_t'(WIDE_MIN);
    end
    return wide_t'(v);
  endfunction

  function automatic smp_t sat_smp(input logic signed [31:0] v);
    if (v > SMP_MAX) begin
      return smp_t'(SMP_MAX);
    end else if (v < SMP_MIN) begin
      return smp_t'(SMP_MIN);
    end
    return smp_t'(v);
  endfunction

endpackage

// ===== hdl/ots_if.sv =====
`timescale 1ns / 1ps
interface ots_in_if;
  logic               valid;
  logic               ready;
  ots_pkg::smp_t      sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface ots_out_if;
  logic               valid;
  logic               ready;
  ots_pkg::smp_t      sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface ots_cfg_if;
  logic                valid;
  logic                ready;
  ots_pkg::cfg_idx_t   index;
  ots_pkg::cfg_word_t  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/oversampled_tube_saturator.sv =====
`timescale 1ns / 1ps
// Channel  | Interface   | Payload                          | Transaction
// ---------+-------------+----------------------------------+-------------------------
// cfg      | ots_cfg_if  | index[1:0], data[15:0]           | valid & ready, always ready
// sample   | ots_in_if   | sample_in[15:0] signed Q1.15     | valid & ready, ready in idle
// result   | ots_out_if  | sample_out[15:0] signed Q1.15    | valid & ready
//
// Each sample runs four oversampled points, each through the shared 22x22 multiplier and a
// 16-step restoring divider for tanh (skipped when tanh saturates), then blend, lowpass and
// makeup gain.
// Synchronous active-high reset restores the register defaults and clears filter state.
// A finished sample waits in the output register; the next sample can be taken meanwhile,
// and the sequencer holds in its last step only if the previous result is still untaken.
module oversampled_tube_saturator (
  input  logic      clk,
  input  logic      rst,
  ots_cfg_if.sink   cfg,
  ots_in_if.sink    sample,
  ots_out_if.source result
);

  ots_pkg::state_t    state, state_next, ret, ret_next;
  ots_pkg::cfg_word_t drive_gain, lpf_alpha, makeup_gain;
  ots_pkg::smp_t      prev_input, prev_shaped, xin, x, avg, out_data;
  ots_pkg::wide_t     filt;
  ots_pkg::diff_t     diff;
  ots_pkg::kd_t       kd;
  ots_pkg::sum_t      sum;
  ots_pkg::kidx_t     k;
  ots_pkg::op_t       opa, opb;
  ots_pkg::prod_t     prod;
  ots_pkg::div_t      rem, dsh;
  ots_pkg::quo_t      q;
  ots_pkg::cnt_t      cnt;
  logic               neg;
  logic               out_valid;
  logic               load_out;

  ots_pkg::kd_t       kd_n;
  ots_pkg::kd_t       w_full;
  ots_pkg::smp_t      w;
  ots_pkg::op_t       x2, t, u3, p, zw, a_n, a2;
  ots_pkg::wide_t     z, s, f_new;
  logic               a_sat;
  ots_pkg::div_t      a2d, den_n;
  logic               ge;
  ots_pkg::smp_t      mag, avg_n, o;
  ots_pkg::sum_t      val;
  ots_pkg::op_t       alpha_op, drive_op, makeup_op;

  always_comb begin
    kd_n      = kd + ots_pkg::kd_t'(diff);
    w_full    = ots_pkg::kd_t'(prev_input) + (kd_n >>> ots_pkg::OS_SHIFT);
    w         = ots_pkg::smp_t'(w_full);
    x2        = ots_pkg::op_t'(prod >>> ots_pkg::FRAC);
    t         = (x2 <<< 1) + x2 - ots_pkg::TWO_ONE;
    u3        = ots_pkg::op_t'(prod >>> (ots_pkg::FRAC - 2)) + ots_pkg::THREE_ONE;
    p         = ots_pkg::op_t'(prod >>> ots_pkg::FRAC);
    z         = ots_pkg::sat_wide(32'(prod >>> ots_pkg::COEF_FRAC));
    zw        = ots_pkg::op_t'(z);
    a_n       = z[ots_pkg::WIDE_W-1] ? -zw : zw;
    a_sat     = a_n >= ots_pkg::THREE_ONE;
    a2        = ots_pkg::op_t'(prod >>> ots_pkg::FRAC);
    a2d       = ots_pkg::div_t'(a2);
    den_n     = (a2d << 3) + a2d + ots_pkg::div_t'(ots_pkg::K27_ONE);
    ge        = rem >= dsh;
    mag       = q[ots_pkg::QB-1] ? ots_pkg::smp_t'(ots_pkg::SMP_MAX)
                                 : ots_pkg::smp_t'({1'b0, q[ots_pkg::QB-2:0]});
    val       = neg ? -ots_pkg::sum_t'(mag) : ots_pkg::sum_t'(mag);
    avg_n     = ots_pkg::smp_t'(sum >>> ots_pkg::OS_SHIFT);
    s         = ots_pkg::sat_wide(32'(prev_shaped) + 32'(prod >>> ots_pkg::COEF_FRAC));
    f_new     = ots_pkg::sat_wide(32'(filt) + 32'(prod >>> ots_pkg::COEF_FRAC));
    o         = ots_pkg::sat_smp(32'(prod >>> 12));
    alpha_op  = ots_pkg::op_t'({1'b0, lpf_alpha});
    drive_op  = ots_pkg::op_t'({1'b0, drive_gain});
    makeup_op = ots_pkg::op_t'({1'b0, makeup_gain});
  end

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ots_pkg::S_IDLE: if (sample.valid) state_next = ots_pkg::S_PT;
      ots_pkg::S_PT: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_SQ;
      end
      ots_pkg::S_SQ: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_T;
      end
      ots_pkg::S_T: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_U;
      end
      ots_pkg::S_U: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_D;
      end
      ots_pkg::S_D: begin
        if (a_sat) begin
          state_next = ots_pkg::S_ACC;
        end else begin
          state_next = ots_pkg::S_WAIT;
          ret_next   = ots_pkg::S_A;
        end
      end
      ots_pkg::S_A: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_N;
      end
      ots_pkg::S_N:   state_next = ots_pkg::S_DIV;
      ots_pkg::S_DIV: if (cnt == '0) state_next = ots_pkg::S_ACC;
      ots_pkg::S_ACC: state_next = (k == ots_pkg::K_LAST) ? ots_pkg::S_BL : ots_pkg::S_PT;
      ots_pkg::S_BL: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_S;
      end
      ots_pkg::S_S: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_F;
      end
      ots_pkg::S_F: begin
        state_next = ots_pkg::S_WAIT;
        ret_next   = ots_pkg::S_O;
      end
      ots_pkg::S_O:    if (load_out) state_next = ots_pkg::S_IDLE;
      ots_pkg::S_WAIT: state_next = ret;
      default:         state_next = ots_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample.ready      = (state == ots_pkg::S_IDLE);
    cfg.ready         = 1'b1;
    result.valid      = out_valid;
    result.sample_out = out_data;
    load_out          = (state == ots_pkg::S_O) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ots_pkg::S_IDLE;
      ret         <= ots_pkg::S_IDLE;
      drive_gain  <= ots_pkg::DRIVE_RST;
      lpf_alpha   <= ots_pkg::ALPHA_RST;
      makeup_gain <= ots_pkg::MAKEUP_RST;
      prev_input  <= '0;
      prev_shaped <= '0;
      filt        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          ots_pkg::REG_DRIVE:  drive_gain  <= cfg.data;
          ots_pkg::REG_ALPHA:  lpf_alpha   <= cfg.data;
          ots_pkg::REG_MAKEUP: makeup_gain <= cfg.data;
          default: ;
        endcase
      end
      if (state == ots_pkg::S_BL) prev_input <= xin;
      if (state == ots_pkg::S_S) prev_shaped <= avg;
      if (state == ots_pkg::S_F) filt <= f_new;
      if (result.ready) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  always_ff @(posedge clk) begin
    case (state)
      ots_pkg::S_IDLE: begin
        xin  <= sample.sample_in;
        diff <= ots_pkg::diff_t'(sample.sample_in) - ots_pkg::diff_t'(prev_input);
        kd   <= '0;
        sum  <= '0;
        k    <= '0;
      end
      ots_pkg::S_PT: begin
        kd  <= kd_n;
        x   <= w;
        opa <= ots_pkg::op_t'(w);
        opb <= ots_pkg::op_t'(w);
      end
      ots_pkg::S_SQ: begin
        opa <= x2;
        opb <= t;
      end
      ots_pkg::S_T: begin
        opa <= ots_pkg::op_t'(x);
        opb <= u3;
      end
      ots_pkg::S_U: begin
        opa <= p;
        opb <= drive_op;
      end
      ots_pkg::S_D: begin
        neg <= z[ots_pkg::WIDE_W-1];
        opa <= a_n;
        opb <= a_n;
        if (a_sat) q <= ots_pkg::SAT_Q;
      end
      ots_pkg::S_A: begin
        opb <= ots_pkg::K27_ONE + a2;
        dsh <= den_n << ots_pkg::FRAC;
      end
      ots_pkg::S_N: begin
        rem <= ots_pkg::div_t'(prod);
        cnt <= ots_pkg::CNT_START;
      end
      ots_pkg::S_DIV: begin
        if (ge) rem <= rem - dsh;
        q[cnt] <= ge;
        dsh    <= dsh >> 1;
        cnt    <= cnt - 1'b1;
      end
      ots_pkg::S_ACC: begin
        sum <= sum + val;
        k   <= k + 1'b1;
      end
      ots_pkg::S_BL: begin
        avg <= avg_n;
        opa <= alpha_op;
        opb <= ots_pkg::op_t'(avg_n) - ots_pkg::op_t'(prev_shaped);
      end
      ots_pkg::S_S: begin
        opb <= ots_pkg::op_t'(s) - ots_pkg::op_t'(filt);
      end
      ots_pkg::S_F: begin
        opa <= ots_pkg::op_t'(f_new);
        opb <= makeup_op;
      end
      ots_pkg::S_O: begin
        if (load_out) out_data <= o;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/ots_checker.sv =====
`timescale 1ns / 1ps
module ots_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ots_pkg::smp_t out_data
);

  // busy for the whole of a sample
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after input");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result dropped or changed");

endmodule

bind oversampled_tube_saturator ots_checker u_ots_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.sample_out)
);

// ===== tb/tb_oversampled_tube_saturator.sv =====
`timescale 1ns / 1ps
module tb_oversampled_tube_saturator;

  localparam longint ONE_L   = longint'(1) <<< ots_pkg::FRAC;
  localparam longint SMP_HI  = ONE_L - 1;
  localparam longint SMP_LO  = -ONE_L;
  localparam longint WIDE_HI = (longint'(1) <<< (ots_pkg::WIDE_W - 1)) - 1;
  localparam longint WIDE_LO = -(longint'(1) <<< (ots_pkg::WIDE_W - 1));

  localparam ots_pkg::cfg_idx_t REG_NONE = ots_pkg::cfg_idx_t'(3);

  localparam int PLAN_LEN     = 29;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 250;
  localparam int DRAIN_CYCLES = 200;

  typedef enum bit {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    ots_pkg::cfg_idx_t idx;
    logic [15:0]       value;
    bit                typed;
    ots_pkg::smp_t     want;
  } plan_row_t;

  logic clk;
  logic rst;

  ots_cfg_if cfg_bus ();
  ots_in_if  in_bus ();
  ots_out_if out_bus ();

  oversampled_tube_saturator i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sample (in_bus),
    .result (out_bus)
  );

  // shadow registers and filter state
  longint drive_q;
  longint alpha_q;
  longint makeup_q;
  longint last_in;
  longint last_shaped;
  longint lp_state;

  ots_pkg::smp_t expected_out[$];
  ots_pkg::smp_t out_want;
  int unsigned   bad_count;
  bit            tx_free;
  bit            rx_free;
  longint        walk_smp;
  plan_row_t     plan [PLAN_LEN];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint shape_poly(longint x);
    longint x2, t, u;
    x2 = (x * x) >>> ots_pkg::FRAC;
    t  = 3 * x2 - 2 * ONE_L;
    u  = (4 * x2 * t) >>> ots_pkg::FRAC;
    return (x * (u + 3 * ONE_L)) >>> ots_pkg::FRAC;
  endfunction

  function automatic longint soft_clip(longint z);
    longint a, a2, mag;
    a = (z < 0) ? -z : z;
    if (a >= 3 * ONE_L) begin
      mag = SMP_HI;
    end else begin
      a2  = (a * a) >>> ots_pkg::FRAC;
      mag = (a * (27 * ONE_L + a2)) / (27 * ONE_L + 9 * a2);
      if (mag > SMP_HI) begin
        mag = SMP_HI;
      end
    end
    return (z < 0) ? -mag : mag;
  endfunction

  function automatic ots_pkg::smp_t tube_next(ots_pkg::smp_t x_in);
    longint y0, y2, diff, w, z, sum, avg, s, f;
    int k;
    y0   = last_in;
    y2   = x_in;
    diff = y2 - y0;
    sum  = 0;
    for (k = 1; k <= ots_pkg::OS_N; k++) begin
      w   = y0 + ((k * diff) >>> ots_pkg::OS_SHIFT);
      z   = (shape_poly(w) * drive_q) >>> 15;
      sum = sum + soft_clip(clip(z, WIDE_LO, WIDE_HI));
    end
    avg         = sum >>> ots_pkg::OS_SHIFT;
    last_in     = y2;
    s           = clip(last_shaped + ((alpha_q * (avg - last_shaped)) >>> 15), WIDE_LO, WIDE_HI);
    last_shaped = avg;
    f           = clip(lp_state + ((alpha_q * (s - lp_state)) >>> 15), WIDE_LO, WIDE_HI);
    lp_state    = f;
    return ots_pkg::smp_t'(clip((f * makeup_q) >>> 12, SMP_LO, SMP_HI));
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic ots_pkg::cfg_word_t pick_coef();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return ots_pkg::cfg_word_t'(0);
      1: return ots_pkg::cfg_word_t'(16'hFFFF);
      2: return ots_pkg::cfg_word_t'(16'h8000);
      3, 4, 5: return ots_pkg::cfg_word_t'($urandom_range(16384, 32768));
      default: return ots_pkg::cfg_word_t'($urandom);
    endcase
  endfunction

  function automatic ots_pkg::cfg_word_t pick_gain();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return ots_pkg::cfg_word_t'(0);
      1: return ots_pkg::cfg_word_t'(16'hFFFF);
      2, 3, 4, 5: return ots_pkg::cfg_word_t'($urandom_range(2048, 8192));
      default: return ots_pkg::cfg_word_t'($urandom);
    endcase
  endfunction

  function automatic ots_pkg::smp_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 4))
        0: return ots_pkg::smp_t'(16'sh7FFF);
        1: return ots_pkg::smp_t'(16'sh8000);
        2: return ots_pkg::smp_t'(0);
        3: return ots_pkg::smp_t'(16'shFFFF);
        default: return ots_pkg::smp_t'(1);
      endcase
    end else if (r < 40) begin
      return ots_pkg::smp_t'(longint'($urandom_range(0, 8191)) - 4096);
    end else if (r < 60) begin
      walk_smp = clip(walk_smp + longint'($urandom_range(0, 4095)) - 2048, SMP_LO, SMP_HI);
      return ots_pkg::smp_t'(walk_smp);
    end
    return ots_pkg::smp_t'($urandom);
  endfunction

  function automatic plan_row_t cfg_row(ots_pkg::cfg_idx_t idx, logic [15:0] value);
    return '{kind: ROW_CFG, idx: idx, value: value, typed: 1'b0, want: '0};
  endfunction

  function automatic plan_row_t smp_row(logic [15:0] value, bit typed, ots_pkg::smp_t want);
    return '{kind: ROW_SMP, idx: REG_NONE, value: value, typed: typed, want: want};
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
  endtask

  task automatic idle_tx(int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_sample(ots_pkg::smp_t v, bit typed, ots_pkg::smp_t want);
    ots_pkg::smp_t pred;
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pred = tube_next(v);
    expected_out.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(ots_pkg::cfg_idx_t idx, ots_pkg::cfg_word_t data);
    wait_drained();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      ots_pkg::REG_DRIVE:  drive_q  = data;
      ots_pkg::REG_ALPHA:  alpha_q  = data;
      ots_pkg::REG_MAKEUP: makeup_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_out.size() == 0) begin
        $error("sample_out: expected none, got %0d", out_bus.sample_out);
        bad_count++;
      end else begin
        out_want = expected_out.pop_front();
        if (out_bus.sample_out !== out_want) begin
          $error("sample_out: expected %0d, got %0d", out_want, out_bus.sample_out);
          bad_count++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned n;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk);
      n = rx_free ? 0 : gap_len();
      if (n > 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    int i, ph, j;
    rst              = 1'b1;
    in_bus.valid     = 1'b0;
    in_bus.sample_in = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = ots_pkg::REG_DRIVE;
    cfg_bus.data     = '0;
    bad_count        = 0;
    tx_free          = 1'b0;
    rx_free          = 1'b0;
    walk_smp         = 0;
    drive_q          = ots_pkg::DRIVE_RST;
    alpha_q          = ots_pkg::ALPHA_RST;
    makeup_q         = ots_pkg::MAKEUP_RST;
    last_in          = 0;
    last_shaped      = 0;
    lp_state         = 0;

    plan = '{
      smp_row(16'h0000, 1'b1, 16'sh0000),
      smp_row(16'h7FFF, 1'b0, '0),
      smp_row(16'h8000, 1'b0, '0),
      smp_row(16'h8000, 1'b0, '0),
      smp_row(16'h0001, 1'b0, '0),
      cfg_row(ots_pkg::REG_MAKEUP, 16'h0000),
      smp_row(16'd12345, 1'b1, 16'sh0000),
      smp_row(16'hFFFF, 1'b1, 16'sh0000),
      // unity alpha, full makeup: output pinned at the rails
      cfg_row(ots_pkg::REG_ALPHA, 16'h8000),
      cfg_row(ots_pkg::REG_MAKEUP, 16'hFFFF),
      smp_row(16'h7FFF, 1'b1, 16'sh7FFF),
      smp_row(16'h7FFF, 1'b1, 16'sh7FFF),
      smp_row(16'h8000, 1'b1, 16'sh8000),
      smp_row(16'h8000, 1'b1, 16'sh8000),
      cfg_row(ots_pkg::REG_DRIVE, 16'h0000),
      cfg_row(ots_pkg::REG_ALPHA, 16'h0000),
      cfg_row(ots_pkg::REG_MAKEUP, 16'h1000),
      smp_row(16'd20000, 1'b0, '0),
      cfg_row(ots_pkg::REG_DRIVE, 16'hFFFF),
      cfg_row(ots_pkg::REG_ALPHA, 16'hFFFF),
      smp_row(16'h7FFF, 1'b0, '0),
      smp_row(16'h8000, 1'b0, '0),
      smp_row(16'h4000, 1'b0, '0),
      cfg_row(REG_NONE, 16'hFFFF),
      smp_row(16'hC000, 1'b0, '0),
      cfg_row(REG_NONE, 16'h0000),
      cfg_row(ots_pkg::REG_DRIVE, ots_pkg::DRIVE_RST),
      cfg_row(ots_pkg::REG_ALPHA, ots_pkg::ALPHA_RST),
      smp_row(16'h0000, 1'b0, '0)
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(ots_pkg::smp_t'(plan[i].value), plan[i].typed, plan[i].want);
        idle_tx(gap_len());
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(ots_pkg::REG_DRIVE, pick_coef());
      write_reg(ots_pkg::REG_ALPHA, pick_coef());
      write_reg(ots_pkg::REG_MAKEUP, pick_gain());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_NONE, ots_pkg::cfg_word_t'($urandom));
      end
      tx_free = (ph % 3 == 1);
      rx_free = (ph % 3 == 2);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        send_sample(pick_sample(), 1'b0, '0);
        if ($urandom_range(0, 149) == 0) begin
          wait_drained();
        end else begin
          idle_tx(tx_free ? 0 : gap_len());
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
